@@ hdl/genomic_interval_gap_partitioner_core_macros.svh @@
// Assertion macros used by the interval gap partitioner core RTL.
`ifndef GENOMIC_INTERVAL_GAP_PARTITIONER_CORE_MACROS_SVH
`define GENOMIC_INTERVAL_GAP_PARTITIONER_CORE_MACROS_SVH

// Implication in the same cycle, checked outside reset.
`define GIGP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication in the next cycle, checked outside reset.
`define GIGP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/gigp_pkg.sv @@
// Package with the types and constants of the interval gap partitioner.
`default_nettype none

package gigp_pkg;

   // Field widths.
   localparam int unsigned COORD_W  = 32;
   localparam int unsigned DELTA_W  = 24;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   // Most results one transaction can cause.
   localparam int unsigned MAX_RESULTS = 4;
   localparam int unsigned SLOT_IDX_W  = 2;
   localparam int unsigned SLOT_CNT_W  = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_FLANK_DELTA = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SKIP_END    = 4'd1;

   // Reset values of the configuration registers.
   localparam logic [DELTA_W-1:0] FLANK_DELTA_RESET = 24'd500;
   localparam logic               SKIP_END_RESET    = 1'b0;

   // Request kinds.
   localparam logic REQ_LOCUS     = 1'b0;
   localparam logic REQ_EMPTY_SEQ = 1'b1;

   // One captured input transaction.
   typedef struct packed {
      logic               req_type;
      logic [COORD_W-1:0] seq_start;
      logic [COORD_W-1:0] seq_end;
      logic [COORD_W-1:0] locus_start;
      logic [COORD_W-1:0] locus_end;
      logic               first_locus;
      logic               last_locus;
   } req_item_type;

   // One emitted interval, without its end-of-run flag.
   typedef struct packed {
      logic [COORD_W-1:0] range_start;
      logic [COORD_W-1:0] range_end;
      logic               is_gap_interval;
   } range_type;

endpackage

`default_nettype wire

@@ hdl/gigp_channels.sv @@
// Valid/ready channel interfaces of the interval gap partitioner.
`default_nettype none

// Request channel: one locus or one empty sequence per transaction.
interface gigp_req_if;
   import gigp_pkg::*;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [COORD_W-1:0] seq_start;
   logic [COORD_W-1:0] seq_end;
   logic [COORD_W-1:0] locus_start;
   logic [COORD_W-1:0] locus_end;
   logic               first_locus;
   logic               last_locus;

   modport source (output valid, req_type, seq_start, seq_end, locus_start,
                   locus_end, first_locus, last_locus, input ready);
   modport sink (input valid, req_type, seq_start, seq_end, locus_start,
                 locus_end, first_locus, last_locus, output ready);
endinterface

// Response channel: one emitted interval per transaction.
interface gigp_rsp_if;
   import gigp_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] range_start;
   logic [COORD_W-1:0] range_end;
   logic               is_gap_interval;
   logic               last_of_run;

   modport source (output valid, range_start, range_end, is_gap_interval,
                   last_of_run, input ready);
   modport sink (input valid, range_start, range_end, is_gap_interval,
                 last_of_run, output ready);
endinterface

// Configuration write channel.
interface gigp_csr_if;
   import gigp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

@@ hdl/genomic_interval_gap_partitioner_core.sv @@
// Top level of the interval gap partitioner: tiles sequences around sorted loci.
//
//   Channel  Direction  Transaction
//   req_ch   in         one locus of a sequence, or one sequence without loci
//   rsp_ch   out        one interval, flagged as gap or locus, end of run marked
//   csr_ch   in         write of flank_delta (index 0) or skip_end_intervals (1)
//
// A request is captured in an input register; once the result buffer is empty
// or hands out its last interval, its zero to four intervals are computed in
// one pass and loaded into a four-slot result buffer. The buffer drives the
// response port and gives one interval per cycle while rsp_ch.ready is high.
// The input register takes the next request while the buffer still drains.
// Reset is synchronous: it empties both stages, clears the open locus and
// restores the configuration defaults. Configuration writes are taken at once.
`default_nettype none

`include "genomic_interval_gap_partitioner_core_macros.svh"

module genomic_interval_gap_partitioner_core (
   input  wire logic   clock,
   input  wire logic   reset,
   gigp_req_if.sink    req_ch,
   gigp_rsp_if.source  rsp_ch,
   gigp_csr_if.sink    csr_ch
);
   import gigp_pkg::*;

   // Configuration, with the flank multiples kept precomputed.
   logic [DELTA_W-1:0]   delta_ff;
   logic [DELTA_W:0]     delta2_ff;
   logic [DELTA_W+1:0]   delta3_ff;
   logic                 skip_ff;

   // Input register.
   logic                 in_vld_ff;
   req_item_type         in_item_ff;

   // Open locus.
   logic [COORD_W-1:0]   pend_start_ff;
   logic [COORD_W-1:0]   pend_end_ff;
   logic [COORD_W-1:0]   pend_start_in;
   logic [COORD_W-1:0]   pend_end_in;

   // Result buffer.
   range_type            slot_ff [MAX_RESULTS];
   range_type            slot_in [MAX_RESULTS];
   logic [SLOT_CNT_W-1:0] cnt_ff;
   logic [SLOT_CNT_W-1:0] cnt_in;
   logic [SLOT_IDX_W-1:0] hd_ff;

   logic                 rsp_fire;
   logic                 head_last;
   logic                 load;

   // Configuration port is always ready.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delta_ff  <= FLANK_DELTA_RESET;
         delta2_ff <= {FLANK_DELTA_RESET, 1'b0};
         delta3_ff <= {1'b0, FLANK_DELTA_RESET, 1'b0} + {2'b00, FLANK_DELTA_RESET};
         skip_ff   <= SKIP_END_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FLANK_DELTA: begin
               delta_ff  <= csr_ch.wdata[DELTA_W-1:0];
               delta2_ff <= {csr_ch.wdata[DELTA_W-1:0], 1'b0};
               delta3_ff <= {1'b0, csr_ch.wdata[DELTA_W-1:0], 1'b0}
                            + {2'b00, csr_ch.wdata[DELTA_W-1:0]};
            end
            CSR_SKIP_END: begin
               skip_ff <= csr_ch.wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Buffer handshake: the head slot ends the run when it is the last filled one.
   assign rsp_fire  = rsp_ch.valid && rsp_ch.ready;
   assign head_last = ({1'b0, hd_ff} + 3'd1) == cnt_ff;
   assign load      = in_vld_ff && ((cnt_ff == '0) || (rsp_fire && head_last));
   assign req_ch.ready = !in_vld_ff || load;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.req_type    <= req_ch.req_type;
         in_item_ff.seq_start   <= req_ch.seq_start;
         in_item_ff.seq_end     <= req_ch.seq_end;
         in_item_ff.locus_start <= req_ch.locus_start;
         in_item_ff.locus_end   <= req_ch.locus_end;
         in_item_ff.first_locus <= req_ch.first_locus;
         in_item_ff.last_locus  <= req_ch.last_locus;
      end
   end

   // Single pass over the captured request: builds the interval list in order.
   always_comb begin
      logic [COORD_W-1:0]    ss;
      logic [COORD_W-1:0]    se;
      logic [COORD_W-1:0]    ls;
      logic [COORD_W-1:0]    le;
      logic [COORD_W-1:0]    d32;
      logic [COORD_W-1:0]    ls_md;
      logic [COORD_W:0]      start_lim;
      logic [COORD_W+1:0]    pe_d;
      logic [COORD_W+1:0]    pe_d2;
      logic [COORD_W+1:0]    pe_d3;
      logic [COORD_W+1:0]    ls_w;
      logic [COORD_W:0]      mid_sum;
      logic [COORD_W-1:0]    mid;
      logic [COORD_W-1:0]    d2_32;
      logic [COORD_W-1:0]    limit;
      logic [COORD_W-1:0]    cur_start;
      logic [SLOT_CNT_W-1:0] n;

      ss    = in_item_ff.seq_start;
      se    = in_item_ff.seq_end;
      ls    = in_item_ff.locus_start;
      le    = in_item_ff.locus_end;
      d32   = {8'b0, delta_ff};
      d2_32 = {7'b0, delta2_ff};
      ls_md = ls - d32;
      start_lim = {1'b0, ss} + {8'b0, delta2_ff};
      ls_w  = {2'b00, ls};
      pe_d  = {2'b00, pend_end_ff} + {10'b0, delta_ff};
      pe_d2 = {2'b00, pend_end_ff} + {9'b0, delta2_ff};
      pe_d3 = {2'b00, pend_end_ff} + {8'b0, delta3_ff};
      mid_sum = {1'b0, pend_end_ff} + {1'b0, ls};
      mid   = mid_sum[COORD_W:1];
      limit = (se >= d2_32) ? (se - d2_32) : '0;

      n         = '0;
      cur_start = pend_start_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         slot_in[i] = '0;
      end
      pend_start_in = pend_start_ff;
      pend_end_in   = pend_end_ff;

      if (in_item_ff.req_type == REQ_EMPTY_SEQ) begin
         // Sequence without loci: one interval over all of it.
         slot_in[0] = '{range_start: ss, range_end: se, is_gap_interval: 1'b1};
         n = 3'd1;
      end else begin
         if (in_item_ff.first_locus) begin
            // First locus: snap to the start or open with an end interval.
            if ({1'b0, ls} >= start_lim) begin
               cur_start = ls_md;
               if (!skip_ff) begin
                  slot_in[0] = '{range_start: ss, range_end: ls_md - 32'd1,
                                 is_gap_interval: 1'b1};
                  n = 3'd1;
               end
            end else begin
               cur_start = ss;
            end
         end else if (pe_d >= ls_w) begin
            // Loci close enough to split at the gap.
            slot_in[0] = '{range_start: pend_start_ff, range_end: ls - 32'd1,
                           is_gap_interval: 1'b0};
            n = 3'd1;
            cur_start = pend_end_ff + 32'd1;
         end else if (pe_d2 >= ls_w) begin
            // Each grown by the flank, flanks meet or overlap.
            slot_in[0] = '{range_start: pend_start_ff, range_end: pe_d[COORD_W-1:0],
                           is_gap_interval: 1'b0};
            n = 3'd1;
            cur_start = ls_md;
         end else if (pe_d3 >= ls_w) begin
            // Split at the midpoint of the gap.
            slot_in[0] = '{range_start: pend_start_ff, range_end: mid,
                           is_gap_interval: 1'b0};
            n = 3'd1;
            cur_start = mid + 32'd1;
         end else begin
            // Wide gap: grow both and emit the gap between them.
            slot_in[0] = '{range_start: pend_start_ff, range_end: pe_d[COORD_W-1:0],
                           is_gap_interval: 1'b0};
            slot_in[1] = '{range_start: pe_d[COORD_W-1:0] + 32'd1,
                           range_end: ls_md - 32'd1, is_gap_interval: 1'b1};
            n = 3'd2;
            cur_start = ls_md;
         end

         pend_start_in = cur_start;
         pend_end_in   = le;

         // Last locus: close it against the sequence end.
         if (in_item_ff.last_locus) begin
            if (le <= limit) begin
               slot_in[n[SLOT_IDX_W-1:0]] = '{range_start: cur_start,
                                              range_end: le + d32,
                                              is_gap_interval: 1'b0};
               n = n + 3'd1;
               if (!skip_ff) begin
                  slot_in[n[SLOT_IDX_W-1:0]] = '{range_start: le + d32 + 32'd1,
                                                 range_end: se,
                                                 is_gap_interval: 1'b1};
                  n = n + 3'd1;
               end
            end else begin
               slot_in[n[SLOT_IDX_W-1:0]] = '{range_start: cur_start, range_end: se,
                                              is_gap_interval: 1'b0};
               n = n + 3'd1;
            end
         end
      end
      cnt_in = n;
   end

   // Open locus moves on when a request leaves the input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_start_ff <= '0;
         pend_end_ff   <= '0;
      end else if (load) begin
         pend_start_ff <= pend_start_in;
         pend_end_ff   <= pend_end_in;
      end
   end

   // Result buffer control: load a new list or step to the next slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         hd_ff  <= '0;
      end else if (load) begin
         cnt_ff <= cnt_in;
         hd_ff  <= '0;
      end else if (rsp_fire) begin
         if (head_last) begin
            cnt_ff <= '0;
            hd_ff  <= '0;
         end else begin
            hd_ff <= hd_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   // Response port driven from the head slot.
   assign rsp_ch.valid           = cnt_ff != '0;
   assign rsp_ch.range_start     = slot_ff[hd_ff].range_start;
   assign rsp_ch.range_end       = slot_ff[hd_ff].range_end;
   assign rsp_ch.is_gap_interval = slot_ff[hd_ff].is_gap_interval;
   assign rsp_ch.last_of_run     = head_last;

   // Checks on the result buffer.
   `GIGP_ASSERT_SAME(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 3'd4, "result count above four")
   `GIGP_ASSERT_SAME(a_head_in_range, clock, reset, cnt_ff != '0, {1'b0, hd_ff} < cnt_ff, "head slot beyond filled slots")
   `GIGP_ASSERT_NEXT(a_head_holds, clock, reset, rsp_ch.valid && !rsp_ch.ready && !load, $stable(hd_ff) && $stable(cnt_ff), "stalled result buffer moved")
   `GIGP_ASSERT_NEXT(a_load_drains_input, clock, reset, load && !(req_ch.valid && req_ch.ready), !in_vld_ff, "input register kept a consumed request")

endmodule

`default_nettype wire
